// ===== rtl/rgbhsl_pkg.sv =====
`default_nettype none
package rgbhsl_pkg;
    localparam int COMPONENT_BITS    = 8;
    localparam int HUE_FRACTION_BITS = 6;
    localparam int SATURATION_BITS   = 12;
    localparam int HUE_W   = 15;
    localparam int LIGHT_W = 9;
    localparam int SAT_W   = 13;
    localparam int TOL_W   = 8;

    // Register byte addresses.
    localparam logic [1:0] ADDR_GRAY_TOLERANCE = 2'd0;

    // Hue sector selected by the largest component.
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;
endpackage
`default_nettype wire

// ===== rtl/rgbhsl_if.sv =====
`default_nettype none
interface rgbhsl_if #(
    parameter int W = 24
) (
    input wire logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgbhsl_divider.sv =====
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, a valid bit and a
// sideband word travel with each item. The whole pipe advances on i_en.
module rgbhsl_divider
    import rgbhsl_pkg::*;
#(
    parameter int NW = 20,
    parameter int DW = 9,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NW-1:0]      o_quot,
    output logic [SW-1:0]      o_side
);
    logic [NW:0]       r_vld;
    logic [NW-1:0]     r_num  [NW+1];
    logic [NW-1:0]     r_quo  [NW+1];
    logic [DW:0]       r_rem  [NW+1];
    logic [DW-1:0]     r_den  [NW+1];
    logic [SW-1:0]     r_side [NW+1];

    // Stage zero loads the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_num[0]  <= i_num;
            r_quo[0]  <= '0;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // Each stage brings down one numerator bit and tries a subtraction.
    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW+1:0] w_shift;
        logic [DW+1:0] w_diff;
        assign w_shift = {r_rem[s], r_num[s][NW-1-s]};
        assign w_diff  = w_shift - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_num[s+1]  <= r_num[s];
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
                r_quo[s+1]  <= r_quo[s] | (NW'(!w_diff[DW+1]) << (NW-1-s));
                r_rem[s+1]  <= w_diff[DW+1] ? w_shift[DW:0] : w_diff[DW:0];
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quot  = r_quo[NW];
    assign o_side  = r_side[NW];
endmodule
`default_nettype wire

// ===== rtl/rgbhsl_front.sv =====
`default_nettype none
// Front stages: max/min search, then sector choice, spread, sum, gray flag
// and the divider operands.
module rgbhsl_front
    import rgbhsl_pkg::*;
#(
    parameter int CB = COMPONENT_BITS,
    parameter int HF = HUE_FRACTION_BITS,
    parameter int SB = SATURATION_BITS,
    localparam int HNW = CB + 6 + HF,
    localparam int SNW = CB + SB
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [CB-1:0] i_red,
    input  wire logic [CB-1:0] i_green,
    input  wire logic [CB-1:0] i_blue,
    input  wire logic [TOL_W-1:0] i_tol,
    output logic               o_valid,
    output logic [HNW-1:0]     o_hnum,
    output logic               o_hneg,
    output t_sector            o_sector,
    output logic [CB-1:0]      o_spread,
    output logic [SNW-1:0]     o_snum,
    output logic [CB:0]        o_sden,
    output logic [CB:0]        o_sum,
    output logic               o_gray
);
    localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};
    localparam logic [HNW-1:0] SIXTY = HNW'(60) << HF;

    logic            r_v1;
    logic [CB-1:0]   r_r, r_g, r_b, r_mx, r_mn;
    logic [CB-1:0]   w_mx, w_mn;

    // Stage one: largest and smallest component.
    always_comb begin
        w_mx = i_red;
        w_mn = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue  > w_mx) w_mx = i_blue;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue  < w_mn) w_mn = i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_r  <= i_red;
            r_g  <= i_green;
            r_b  <= i_blue;
            r_mx <= w_mx;
            r_mn <= w_mn;
        end
    end

    // Stage two: sector, signed difference magnitude, operands.
    logic [CB-1:0] w_spread;
    logic [CB:0]   w_sum;
    t_sector       w_sec;
    logic [CB-1:0] w_a, w_b;
    logic [CB-1:0] w_mag;
    logic          w_neg;

    always_comb begin
        w_spread = r_mx - r_mn;
        w_sum    = {1'b0, r_mx} + {1'b0, r_mn};
        if (r_b >= r_mx) begin
            w_sec = SEC_BLUE;  w_a = r_r; w_b = r_g;
        end else if (r_g >= r_mx) begin
            w_sec = SEC_GREEN; w_a = r_b; w_b = r_r;
        end else begin
            w_sec = SEC_RED;   w_a = r_g; w_b = r_b;
        end
        w_neg = w_a < w_b;
        w_mag = w_neg ? (w_b - w_a) : (w_a - w_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
        if (i_en) begin
            o_hnum   <= HNW'(w_mag) * SIXTY;
            o_hneg   <= w_neg;
            o_sector <= w_sec;
            o_spread <= w_spread;
            o_snum   <= SNW'(w_spread) << SB;
            o_sden   <= (w_sum <= FULL) ? w_sum : ((FULL << 1) - w_sum);
            o_sum    <= w_sum;
            o_gray   <= (CB+TOL_W)'(w_spread) <= (CB+TOL_W)'(i_tol);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsl_converter.sv =====
`default_nettype none
// RGB to HSL converter. Takes one pixel per clock on the input channel and
// delivers one result per pixel, in order; the pipeline depth is set by the
// hue and saturation dividers, which share one depth and resolve one
// quotient bit per pipeline stage. Hue is in 1/2^HF degree, lightness is
// max+min, saturation is Q1.SB. A spread of at most gray_tolerance (APB
// register at address 0) marks the pixel gray with zero hue and saturation.
// The whole pipe stalls while the output is held.
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
#(
    parameter int COMPONENT_BITS_P    = COMPONENT_BITS,
    parameter int HUE_FRACTION_BITS_P = HUE_FRACTION_BITS,
    parameter int SATURATION_BITS_P   = SATURATION_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rgbhsl_if.sink       i_pix,
    rgbhsl_if.source     o_hsl,
    input  wire logic    psel,
    input  wire logic    penable,
    input  wire logic    pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int CB  = COMPONENT_BITS_P;
    localparam int HF  = HUE_FRACTION_BITS_P;
    localparam int SB  = SATURATION_BITS_P;
    localparam int HNW = CB + 6 + HF;
    localparam int SNW = CB + SB;
    localparam int DNW = (HNW > SNW) ? HNW : SNW;
    localparam int HW  = 9 + HF;
    localparam int SW  = SB + 1;
    localparam int SIDE = 2 + 1 + (CB + 1) + 1 + SW;
    localparam logic [HW-1:0] H60 = HW'(60) << HF;
    localparam logic [HW-1:0] H360 = HW'(360) << HF;

    // Configuration register.
    logic [TOL_W-1:0] r_tol;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GRAY_TOLERANCE) ? {{(32-TOL_W){1'b0}}, r_tol} : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (psel && penable && pwrite && paddr == ADDR_GRAY_TOLERANCE) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    // Pipe advances unless a finished word is held at the output.
    logic w_en;
    assign w_en = !o_hsl.valid || o_hsl.ready;
    assign i_pix.ready = w_en;

    logic              f_valid, f_hneg, f_gray;
    logic [HNW-1:0]    f_hnum;
    t_sector           f_sec;
    logic [CB-1:0]     f_spread;
    logic [SNW-1:0]    f_snum;
    logic [CB:0]       f_sden, f_sum;

    rgbhsl_front #(.CB(CB), .HF(HF), .SB(SB)) u_front (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(i_pix.valid),
        .i_red(i_pix.data[3*CB-1:2*CB]),
        .i_green(i_pix.data[2*CB-1:CB]),
        .i_blue(i_pix.data[CB-1:0]),
        .i_tol(r_tol),
        .o_valid(f_valid), .o_hnum(f_hnum), .o_hneg(f_hneg), .o_sector(f_sec),
        .o_spread(f_spread), .o_snum(f_snum), .o_sden(f_sden), .o_sum(f_sum),
        .o_gray(f_gray)
    );

    // Saturation quotient, run alongside the hue division at the same depth.
    logic [DNW-1:0] w_squot;
    logic           w_sv;
    logic [0:0]     w_sside;
    rgbhsl_divider #(.NW(DNW), .DW(CB+1), .SW(1)) u_sdiv (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(1'b0),
        .i_num(DNW'(f_snum)), .i_den(f_sden), .i_side(1'b0),
        .o_valid(w_sv), .o_quot(w_squot), .o_side(w_sside)
    );

    logic [DNW-1:0]  w_hquot;
    logic            w_hv;
    logic [SIDE-1:0] w_side;
    rgbhsl_divider #(.NW(DNW), .DW(CB), .SW(SIDE)) u_hdiv (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(f_valid),
        .i_num(DNW'(f_hnum)), .i_den(f_spread | CB'(f_gray)),
        .i_side({f_sec, f_hneg, f_sum, f_gray, SW'(0)}),
        .o_valid(w_hv), .o_quot(w_hquot), .o_side(w_side)
    );

    // Final stage: sector offset, sign, wrap, gray masking.
    t_sector        w_osec;
    logic           w_oneg, w_ogray;
    logic [CB:0]    w_osum;
    logic [HW-1:0]  w_base, w_q, w_hue;
    logic [SW-1:0]  w_sat;
    always_comb begin
        w_osec  = t_sector'(w_side[SIDE-1 -: 2]);
        w_oneg  = w_side[SIDE-3];
        w_osum  = w_side[SIDE-4 -: CB+1];
        w_ogray = w_side[SW];
        w_q     = HW'(w_hquot);
        w_sat   = SW'(w_squot);
        case (w_osec)
            SEC_BLUE:  w_base = H60 << 2;
            SEC_GREEN: w_base = H60 << 1;
            default:   w_base = '0;
        endcase
        if (!w_oneg)           w_hue = w_base + w_q;
        else if (w_base >= w_q) w_hue = w_base - w_q;
        else                   w_hue = H360 - w_q;
    end

    logic              r_ov, r_gray;
    logic [HW-1:0]     r_hue;
    logic [CB:0]       r_sum;
    logic [SW-1:0]     r_sat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_hv;
        end
        if (w_en) begin
            r_hue  <= w_ogray ? '0 : w_hue;
            r_sum  <= w_osum;
            r_sat  <= w_ogray ? '0 : w_sat;
            r_gray <= w_ogray;
        end
    end

    assign o_hsl.valid = r_ov;
    assign o_hsl.data  = {r_hue, r_sum, r_sat, r_gray};

    logic w_unused;
    assign w_unused = w_sv ^ w_sside[0] ^ (^w_side[SW-1:0]);
endmodule
`default_nettype wire
